/* hdl/dvq_pkg.sv */
// ----------------------------------------------------------------------------
// dvq_pkg
// Shared types, widths and the elaboration-time codebook builder for the
// direction vector quantizer.
// ----------------------------------------------------------------------------
package dvq_pkg;

	// Field and datapath widths.
	localparam int TABLE_DEPTH = 128;
	localparam int CODE_W      = 7;
	localparam int COORD_W     = 20;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int COMP_W      = 16;
	localparam int PROD_W      = DIFF_W + COMP_W;
	localparam int DOT_W       = PROD_W + 2;
	localparam int IN_DATA_W   = 6 * COORD_W;
	localparam int OUT_DATA_W  = 8;
	localparam int MAX_STEPS   = 16;

	// Fixed-point constants for the sine and cosine series.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] UNIT_Q14    = 64'd16384;

	// One codebook entry, x in the lowest bits.
	typedef struct packed {
		logic signed [COMP_W-1:0] z;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] x;
	} dvq_entry_t;

	typedef dvq_entry_t [TABLE_DEPTH-1:0] dvq_table_t;

	// Tag that travels with each entry through the dot-product pipeline.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [CODE_W-1:0] idx;
	} dvq_tag_t;

	// Status from the best-entry tracker to the sequencer.
	typedef struct packed {
		logic              done;
		logic [CODE_W-1:0] code;
	} dvq_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} dvq_state_t;

	typedef struct packed {
		logic signed [63:0] sn;
		logic signed [63:0] cs;
	} dvq_sincos_t;

	// Unsigned long division by shift and subtract, used at elaboration only.
	function automatic logic [63:0] dvq_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic int dvq_clamp(input int v);
		if (v < 1) begin
			return 1;
		end
		if (v > MAX_STEPS) begin
			return MAX_STEPS;
		end
		return v;
	endfunction

	// Sine and cosine of num/den turns in signed Q30.
	function automatic dvq_sincos_t dvq_sincos(input logic [63:0] num_in,
	                                           input logic [63:0] den);
		logic [63:0] num, m, k, r, a, a2, t, dv;
		logic signed [63:0] s, c;
		dvq_sincos_t res;
		num = num_in - dvq_udiv(num_in, den) * den;
		m   = num << 2;
		k   = dvq_udiv(m, den);
		r   = m - k * den;
		a   = dvq_udiv(r * HALF_PI_Q30, den);
		a2  = (a * a) >> 30;
		// Sine series up to the twenty-first power.
		s = $signed(a);
		t = a;
		for (int n = 1; n <= 10; n++) begin
			dv = 64'((2 * n) * (2 * n + 1));
			t  = dvq_udiv((t * a2) >> 30, dv);
			if ((n & 1) != 0) begin
				s = s - $signed(t);
			end else begin
				s = s + $signed(t);
			end
		end
		// Cosine series up to the twentieth power.
		c = $signed(ONE_Q30);
		t = ONE_Q30;
		for (int n = 1; n <= 10; n++) begin
			dv = 64'((2 * n - 1) * (2 * n));
			t  = dvq_udiv((t * a2) >> 30, dv);
			if ((n & 1) != 0) begin
				c = c - $signed(t);
			end else begin
				c = c + $signed(t);
			end
		end
		// Quadrant symmetries.
		case (k[1:0])
			2'd0: begin
				res.sn = s;
				res.cs = c;
			end
			2'd1: begin
				res.sn = c;
				res.cs = -s;
			end
			2'd2: begin
				res.sn = -s;
				res.cs = -c;
			end
			default: begin
				res.sn = -c;
				res.cs = s;
			end
		endcase
		return res;
	endfunction

	// Round a fixed-point value to Q1.14, half away from zero, limited to one.
	function automatic logic signed [COMP_W-1:0] dvq_round(input logic signed [63:0] v,
	                                                       input int frac);
		logic [63:0] mag, q;
		logic signed [COMP_W-1:0] mq;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		q   = (mag + (64'd1 << (frac - 1))) >> frac;
		if (q > UNIT_Q14) begin
			q = UNIT_Q14;
		end
		mq = COMP_W'(q);
		return (v < 0) ? -mq : mq;
	endfunction

	function automatic int dvq_entry_count(input int az_in, input int po_in);
		int n;
		n = dvq_clamp(az_in) * dvq_clamp(po_in);
		return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
	endfunction

	// Build the codebook: entry i*po+j is the direction at azimuth step i and
	// polar step j.
	function automatic dvq_table_t dvq_build_table(input int az_in, input int po_in);
		int az, po, idx;
		dvq_sincos_t th, ph;
		dvq_table_t tab;
		tab = '0;
		idx = 0;
		az  = dvq_clamp(az_in);
		po  = dvq_clamp(po_in);
		for (int i = 0; i < MAX_STEPS; i++) begin
			if (i < az) begin
				th = dvq_sincos(64'(i), 64'(az));
				for (int j = 0; j < MAX_STEPS; j++) begin
					if (j < po && idx < TABLE_DEPTH) begin
						ph = dvq_sincos(64'(j), 64'(2 * po));
						tab[idx].x = dvq_round(ph.sn * th.cs, 46);
						tab[idx].y = dvq_round(ph.sn * th.sn, 46);
						tab[idx].z = dvq_round(ph.cs, 16);
						idx++;
					end
				end
			end
		end
		return tab;
	endfunction

endpackage

/* hdl/dvq_dot_unit.sv */
// ----------------------------------------------------------------------------
// dvq_dot_unit
// Shared dot-product unit: one codebook entry per cycle against the held
// displacement, products in the first stage and their sum in the second.
// ----------------------------------------------------------------------------
module dvq_dot_unit
	import dvq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	input  logic signed [DIFF_W-1:0] dz,
	input  dvq_entry_t              entry,
	input  dvq_tag_t                tag_in,
	output logic signed [DOT_W-1:0] dot,
	output dvq_tag_t                tag_out
);

	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [DOT_W-1:0]  sum_s2;
	dvq_tag_t                 tag_s1, tag_s2;

	// Stage 1: three component products.
	always_ff @(posedge clk) begin
		prod_x_s1 <= PROD_W'(dx) * PROD_W'(entry.x);
		prod_y_s1 <= PROD_W'(dy) * PROD_W'(entry.y);
		prod_z_s1 <= PROD_W'(dz) * PROD_W'(entry.z);
	end

	// Stage 2: sum of the products.
	always_ff @(posedge clk) begin
		sum_s2 <= DOT_W'(prod_x_s1) + DOT_W'(prod_y_s1) + DOT_W'(prod_z_s1);
	end

	// The tag follows the data; only its valid bit needs a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	assign dot     = sum_s2;
	assign tag_out = tag_s2;

endmodule

/* hdl/dvq_argmax.sv */
// ----------------------------------------------------------------------------
// dvq_argmax
// Tracks the largest dot product seen during a scan and its entry index.
// The first entry of a scan always loads; later ones win only when larger.
// ----------------------------------------------------------------------------
module dvq_argmax
	import dvq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [DOT_W-1:0] dot,
	input  dvq_tag_t                tag,
	output dvq_result_t             result
);

	logic signed [DOT_W-1:0] best_q;
	logic [CODE_W-1:0]       best_idx_q;
	logic                    done_q;

	// Best value and index; strict compare keeps the lowest index on ties.
	always_ff @(posedge clk) begin
		if (tag.valid && (tag.first || dot > best_q)) begin
			best_q     <= dot;
			best_idx_q <= tag.idx;
		end
	end

	// One-cycle pulse once the last entry has been compared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag.valid && tag.last;
		end
	end

	assign result.done = done_q;
	assign result.code = best_idx_q;

endmodule

/* hdl/direction_vector_quantizer.sv */
// ----------------------------------------------------------------------------
// direction_vector_quantizer
// Quantizes the direction from a start point to an end point to the index of
// the codebook direction with the largest dot product.
// ----------------------------------------------------------------------------
// Usage:
// An item on the s_ channel carries a start and an end point. The block forms
// the displacement and scans the codebook of AZIMUTH_STEPS * POLAR_STEPS unit
// vectors (at most 128), one entry per cycle through a single shared
// dot-product unit. The result item on the m_ channel is the winning index;
// ties go to the lowest index and a zero displacement gives index 0.
// s_tready is high only in the idle state and stays low during the scan, the
// drain and the wait for the output register, so the block takes no new item
// until it is through with the last one. The scan of the codebook entries
// through the dot-product unit sets the pace.
// A result waits in the output register until taken; the next item is
// accepted meanwhile, and its result is held back until the register frees.
// The codebook is a constant table built at elaboration, so reset returns the
// sequencer and entry counter to idle, clears the tags, done and output valid.
// ----------------------------------------------------------------------------
module direction_vector_quantizer
	import dvq_pkg::*;
#(
	parameter int AZIMUTH_STEPS = 16,
	parameter int POLAR_STEPS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata from bit 0: start_x, start_y, start_z, end_x, end_y, end_z.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// m_tdata from bit 0: direction_code, then one zero bit.
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready
);

	localparam dvq_table_t DIR_TABLE   = dvq_build_table(AZIMUTH_STEPS, POLAR_STEPS);
	localparam int         ENTRY_COUNT = dvq_entry_count(AZIMUTH_STEPS, POLAR_STEPS);
	localparam logic [CODE_W-1:0] LAST_IDX = CODE_W'(ENTRY_COUNT - 1);

	dvq_state_t state_q, state_d;
	logic [CODE_W-1:0] idx_q, idx_d;
	logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic [CODE_W-1:0] code_q;
	logic out_valid_q, out_load, in_accept;
	dvq_tag_t tag_issue, tag_dot;
	logic signed [DOT_W-1:0] dot;
	dvq_result_t result;

	assign in_accept = s_tvalid && s_tready;

	// Displacement, held for the whole scan.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dx_q <= DIFF_W'($signed(s_tdata[3*COORD_W +: COORD_W]))
			      - DIFF_W'($signed(s_tdata[0*COORD_W +: COORD_W]));
			dy_q <= DIFF_W'($signed(s_tdata[4*COORD_W +: COORD_W]))
			      - DIFF_W'($signed(s_tdata[1*COORD_W +: COORD_W]));
			dz_q <= DIFF_W'($signed(s_tdata[5*COORD_W +: COORD_W]))
			      - DIFF_W'($signed(s_tdata[2*COORD_W +: COORD_W]));
		end
	end

	// Sequencer state and entry counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Next state, entry issue and output load.
	always_comb begin
		state_d         = state_q;
		idx_d           = idx_q;
		s_tready        = 1'b0;
		out_load        = 1'b0;
		tag_issue       = '0;
		tag_issue.idx   = idx_q;
		tag_issue.first = (idx_q == '0);
		tag_issue.last  = (idx_q == LAST_IDX);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				idx_d    = '0;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				tag_issue.valid = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (result.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			code_q <= result.code;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(code_q);

	// Shared dot-product unit fed from the constant codebook.
	dvq_dot_unit u_dot (
		.clk     (clk),
		.arst_n  (arst_n),
		.dx      (dx_q),
		.dy      (dy_q),
		.dz      (dz_q),
		.entry   (DIR_TABLE[idx_q]),
		.tag_in  (tag_issue),
		.dot     (dot),
		.tag_out (tag_dot)
	);

	// Best-entry tracker.
	dvq_argmax u_argmax (
		.clk    (clk),
		.arst_n (arst_n),
		.dot    (dot),
		.tag    (tag_dot),
		.result (result)
	);

endmodule

/* tb/direction_vector_quantizer_test.sv */
// ----------------------------------------------------------------------------
// direction_vector_quantizer_test
// Checks the direction quantizer against a predictor that builds its own copy
// of the codebook and scans it for the largest dot product. A directed set of
// extreme and degenerate displacements runs first, then random items mixing
// full-range points, exact codebook directions, tiny and axis displacements.
// Both stream sides idle at random, with a long output hold-off that fills
// the block and a pause that drains it.
// ----------------------------------------------------------------------------
module direction_vector_quantizer_test;
	import dvq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AZIMUTH_STEPS = 16;
	localparam int POLAR_STEPS   = 8;
	localparam int ENTRY_COUNT   = (AZIMUTH_STEPS * POLAR_STEPS > 128) ? 128 :
	                               AZIMUTH_STEPS * POLAR_STEPS;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int HOLD_CYCLES   = 600;
	localparam int SCAN_CYCLES   = ENTRY_COUNT + 4;

	typedef longint unsigned u64_t;

	// One input item, start_x in the lowest bits as on s_tdata.
	typedef struct packed {
		logic signed [COORD_W-1:0] end_z;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_x;
	} point_pair_t;

	// Expected direction codes and the codebook they are computed from.
	class direction_scoreboard;
		logic signed [15:0] comp_x [128];
		logic signed [15:0] comp_y [128];
		logic signed [15:0] comp_z [128];
		logic [CODE_W-1:0]  pending_codes [$];
		int                 mismatches;

		function new();
			longint st, ct, sp, cp;
			int idx;
			idx = 0;
			mismatches = 0;
			for (int i = 0; i < AZIMUTH_STEPS; i++) begin
				sincos_turn(i, AZIMUTH_STEPS, st, ct);
				for (int j = 0; j < POLAR_STEPS; j++) begin
					if (idx < ENTRY_COUNT) begin
						sincos_turn(j, 2 * POLAR_STEPS, sp, cp);
						comp_x[idx] = round_q14(sp * ct, 46);
						comp_y[idx] = round_q14(sp * st, 46);
						comp_z[idx] = round_q14(cp, 16);
						idx++;
					end
				end
			end
		endfunction

		// Sine and cosine of num/den turns in Q30, by quadrant and Taylor series.
		function void sincos_turn(int unsigned num_in, int unsigned den,
		                          output longint sn, output longint cs);
			u64_t num, m, k, r, a, a2, t;
			longint s, c;
			num = num_in % den;
			m   = 4 * num;
			k   = m / den;
			r   = m % den;
			a   = (r * 64'd1686629713) / den;
			a2  = (a * a) >> 30;
			s = longint'(a);
			t = a;
			for (int n = 1; n <= 10; n++) begin
				t = ((t * a2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
				s = (n % 2 == 1) ? s - longint'(t) : s + longint'(t);
			end
			c = longint'(64'd1 << 30);
			t = 64'd1 << 30;
			for (int n = 1; n <= 10; n++) begin
				t = ((t * a2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
				c = (n % 2 == 1) ? c - longint'(t) : c + longint'(t);
			end
			case (k % 4)
				0: begin sn = s;  cs = c;  end
				1: begin sn = c;  cs = -s; end
				2: begin sn = -s; cs = -c; end
				default: begin sn = -c; cs = s; end
			endcase
		endfunction

		// Round to Q1.14 half away from zero, limited to one.
		function logic signed [15:0] round_q14(longint v, int frac);
			u64_t mag, q;
			mag = (v < 0) ? -v : v;
			q   = (mag + (64'd1 << (frac - 1))) >> frac;
			if (q > 16384) begin
				q = 16384;
			end
			return (v < 0) ? 16'(-q) : 16'(q);
		endfunction

		// First codebook entry with the largest dot product.
		function logic [CODE_W-1:0] nearest_code(point_pair_t p);
			longint dx, dy, dz, dot, best;
			int best_k;
			dx = longint'(p.end_x) - longint'(p.start_x);
			dy = longint'(p.end_y) - longint'(p.start_y);
			dz = longint'(p.end_z) - longint'(p.start_z);
			best   = 0;
			best_k = 0;
			for (int k = 0; k < ENTRY_COUNT; k++) begin
				dot = dx * longint'(comp_x[k]) + dy * longint'(comp_y[k]) +
				      dz * longint'(comp_z[k]);
				if (k == 0 || dot > best) begin
					best   = dot;
					best_k = k;
				end
			end
			return CODE_W'(best_k);
		endfunction

		function void note_item(point_pair_t p);
			pending_codes.push_back(nearest_code(p));
		endfunction

		function void check_code(logic [CODE_W-1:0] code);
			logic [CODE_W-1:0] want;
			if (pending_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: direction_code %0d with no item outstanding", $realtime, code);
				end
				return;
			end
			want = pending_codes.pop_front();
			if (code !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: direction_code expected %0d, got %0d", $realtime, want, code);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;

	direction_scoreboard sb = new();

	// Idling levels in percent and the long output hold-off request.
	int gap_pct   = 0;
	int stall_pct = 0;
	bit hold_req  = 1'b0;

	direction_vector_quantizer #(
		.AZIMUTH_STEPS(AZIMUTH_STEPS),
		.POLAR_STEPS  (POLAR_STEPS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both handshakes; a result is checked before the item taken at the
	// same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_code(m_tdata[CODE_W-1:0]);
			end
			if (s_tvalid && s_tready) begin
				sb.note_item(point_pair_t'(s_tdata));
			end
		end
	end

	// Output side: random stall bursts and one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] wrap20(longint v);
		return v[COORD_W-1:0];
	endfunction

	function automatic point_pair_t pair_of(longint sx, longint sy, longint sz,
	                                        longint ex, longint ey, longint ez);
		point_pair_t p;
		p.start_x = wrap20(sx);
		p.start_y = wrap20(sy);
		p.start_z = wrap20(sz);
		p.end_x   = wrap20(ex);
		p.end_y   = wrap20(ey);
		p.end_z   = wrap20(ez);
		return p;
	endfunction

	// A displacement along codebook entry k, centered so both points fit.
	function automatic point_pair_t along_entry(int k, int scale, int jitter);
		longint dx, dy, dz;
		dx = longint'(sb.comp_x[k]) * scale + $urandom_range(0, 2 * jitter) - jitter;
		dy = longint'(sb.comp_y[k]) * scale + $urandom_range(0, 2 * jitter) - jitter;
		dz = longint'(sb.comp_z[k]) * scale + $urandom_range(0, 2 * jitter) - jitter;
		return pair_of(-(dx >>> 1), -(dy >>> 1), -(dz >>> 1),
		               dx - (dx >>> 1), dy - (dy >>> 1), dz - (dz >>> 1));
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t p;
		longint sx, sy, sz, d;
		int mode;
		mode = $urandom_range(0, 9);
		p = point_pair_t'({$urandom, $urandom, $urandom, $urandom});
		case (mode)
			3, 4, 5: begin
				p = along_entry($urandom_range(0, ENTRY_COUNT - 1), $urandom_range(1, 63), 2);
			end
			6: begin
				// Tiny displacement, where near ties are common.
				p = pair_of(p.start_x, p.start_y, p.start_z,
				            p.start_x + $urandom_range(0, 6) - 3,
				            p.start_y + $urandom_range(0, 6) - 3,
				            p.start_z + $urandom_range(0, 6) - 3);
			end
			7: begin
				// Movement along one axis only.
				sx = longint'(p.start_x) >>> 1;
				sy = longint'(p.start_y) >>> 1;
				sz = longint'(p.start_z) >>> 1;
				d  = longint'(p.end_x) >>> 1;
				case ($urandom_range(0, 2))
					0: p = pair_of(sx, sy, sz, sx + d, sy, sz);
					1: p = pair_of(sx, sy, sz, sx, sy + d, sz);
					default: p = pair_of(sx, sy, sz, sx, sy, sz + d);
				endcase
			end
			8: begin
				p = pair_of($urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50,
				            $urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50,
				            $urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50);
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	// Offer one item, after an optional run of idle bursts, until it is taken.
	task automatic send_pair(point_pair_t p);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end while ($urandom_range(0, 3) == 0);
		end
		s_tdata  <= p;
		s_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_codes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Main stimulus.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero and extreme displacements, unit steps, exact directions.
		send_pair(pair_of(0, 0, 0, 0, 0, 0));
		send_pair(pair_of(12345, -6789, 4242, 12345, -6789, 4242));
		send_pair(pair_of(-524288, 0, 0, 524287, 0, 0));
		send_pair(pair_of(524287, 0, 0, -524288, 0, 0));
		send_pair(pair_of(0, -524288, 0, 0, 524287, 0));
		send_pair(pair_of(0, 524287, 0, 0, -524288, 0));
		send_pair(pair_of(0, 0, -524288, 0, 0, 524287));
		send_pair(pair_of(0, 0, 524287, 0, 0, -524288));
		send_pair(pair_of(-524288, -524288, -524288, 524287, 524287, 524287));
		send_pair(pair_of(524287, 524287, 524287, -524288, -524288, -524288));
		send_pair(pair_of(524287, -524288, 524287, -524288, 524287, -524288));
		send_pair(pair_of(0, 0, 0, 1, 0, 0));
		send_pair(pair_of(0, 0, 0, 0, 1, 0));
		send_pair(pair_of(0, 0, 0, 0, 0, 1));
		send_pair(pair_of(0, 0, 0, 0, 0, -1));
		send_pair(pair_of(0, 0, 0, -1, -1, -1));
		send_pair(pair_of(0, 0, 0, 1, 1, 0));
		send_pair(pair_of(0, 0, 0, -1, 0, 0));
		send_pair(pair_of(0, 0, 0, 0, -1, 0));
		send_pair(pair_of(0, 0, 0, -524288, -524288, -524288));
		send_pair(pair_of(-1, -1, -1, 0, 0, 0));
		send_pair(along_entry(9, 40, 0));
		send_pair(along_entry(71, 63, 0));
		send_pair(along_entry(ENTRY_COUNT - 1, 1, 0));

		// Random items with idling that changes every few hundred items.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 250 == 0) begin
				case ((i / 250) % 4)
					0: begin gap_pct = 30; stall_pct = 30; end
					1: begin gap_pct = 0;  stall_pct = 0;  end
					2: begin gap_pct = 60; stall_pct = 10; end
					default: begin gap_pct = 10; stall_pct = 60; end
				endcase
			end
			if (i >= RANDOM_ITEMS - 300) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			if (i == 700) begin
				hold_req = 1'b1;
			end
			if (i == 1300) begin
				wait_drained();
			end
			send_pair(random_pair());
		end

		wait_drained();
		repeat (2 * SCAN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Give up well beyond the slowest correct run.
	initial begin
		#30_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
